// ----- rtl/ssd_fb_pkg.sv -----
// shared types, byte constants and segment lookup for the display frame builder
package ssd_fb_pkg;

    localparam logic [1:0] CMD_SHOW_NUMBER = 2'd0;
    localparam logic [1:0] CMD_SHOW_DIGIT  = 2'd1;
    localparam logic [1:0] CMD_CLEAR       = 2'd2;

    localparam logic [7:0] BYTE_DATA_WRITE = 8'h40;
    localparam logic [7:0] BYTE_ADDR_BASE  = 8'hC0;
    localparam logic [7:0] BRIGHT_RESET    = 8'h8F;
    localparam logic [7:0] SEG_BLANK       = 8'h00;

    typedef enum logic [1:0] {
        K_NUMBER = 2'd0,
        K_DIGIT  = 2'd1,
        K_CLEAR  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [1:0] pos;
    } t_cmd;

    function automatic logic [7:0] seg_of(input logic [3:0] code);
        logic [7:0] seg;
        case (code)
            4'd0:    seg = 8'h3F;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5B;
            4'd3:    seg = 8'h4F;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h7D;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h6F;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

// ----- rtl/ssd_fb_front.sv -----
// front end: accepts commands, splits the number into decimal digits
module ssd_fb_front #(
    parameter int DIGITS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_command,
    input  logic [15:0]           i_number,
    input  logic [1:0]            i_position,
    input  logic [3:0]            i_digit_code,
    output logic                  o_push,
    output ssd_fb_pkg::t_cmd      o_cmd,
    output logic [DIGITS*4-1:0]   o_dig,
    input  logic                  i_full
);

    localparam int DW = DIGITS * 4;
    localparam int CW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam logic [16:0] RECIP10 = 17'd52429;

    logic              r_busy, n_busy;
    logic              r_ent_vld, n_ent_vld;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [15:0]       r_rem, n_rem;
    logic [DW-1:0]     r_dig, n_dig;
    ssd_fb_pkg::t_cmd  r_cmd, n_cmd;

    logic              accept;
    logic [31:0]       prod;
    logic [15:0]       quot;
    logic [15:0]       rest;
    logic [3:0]        dec;

    assign o_push     = r_ent_vld && !i_full;
    assign o_in_stall = r_busy || (r_ent_vld && !o_push);
    assign accept     = i_in_valid && !o_in_stall;
    assign o_cmd      = r_cmd;
    assign o_dig      = r_dig;

    // divide by ten through the reciprocal, exact for 16-bit values
    assign prod = {16'd0, r_rem} * {15'd0, RECIP10};
    assign quot = {3'd0, prod[31:19]};
    assign rest = r_rem - {quot[12:0], 3'd0} - {quot[14:0], 1'b0};
    assign dec  = rest[3:0];

    always_comb begin
        n_busy    = r_busy;
        n_ent_vld = r_ent_vld;
        n_cnt     = r_cnt;
        n_rem     = r_rem;
        n_dig     = r_dig;
        n_cmd     = r_cmd;
        if (o_push) begin
            n_ent_vld = 1'b0;
        end
        if (r_busy) begin
            // digits shift in from the top, least significant first
            for (int k = 0; k < DIGITS - 1; k++) begin
                n_dig[k*4 +: 4] = r_dig[(k+1)*4 +: 4];
            end
            n_dig[(DIGITS-1)*4 +: 4] = dec;
            n_rem = quot;
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == CW'(DIGITS - 1)) begin
                n_busy    = 1'b0;
                n_ent_vld = 1'b1;
            end
        end
        if (accept) begin
            n_cmd.pos = i_position;
            case (i_command)
                ssd_fb_pkg::CMD_SHOW_NUMBER: begin
                    n_cmd.kind = ssd_fb_pkg::K_NUMBER;
                    n_busy     = 1'b1;
                    n_cnt      = '0;
                    n_rem      = i_number;
                end
                ssd_fb_pkg::CMD_SHOW_DIGIT: begin
                    n_cmd.kind = ssd_fb_pkg::K_DIGIT;
                    n_dig      = '0;
                    n_dig[(DIGITS-1)*4 +: 4] = i_digit_code;
                    n_ent_vld  = 1'b1;
                end
                ssd_fb_pkg::CMD_CLEAR: begin
                    n_cmd.kind = ssd_fb_pkg::K_CLEAR;
                    n_ent_vld  = 1'b1;
                end
                default: begin
                    // unused command is dropped
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_ent_vld <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_busy    <= n_busy;
            r_ent_vld <= n_ent_vld;
            r_cnt     <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dig <= n_dig;
        r_cmd <= n_cmd;
    end

endmodule

// ----- rtl/ssd_fb_queue.sv -----
// two-entry queue between the front end and the byte sequencer
module ssd_fb_queue #(
    parameter int WIDTH = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_vld,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    assign o_full = (r_cnt == 2'd2);
    assign o_vld  = (r_cnt != 2'd0);
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ----- rtl/ssd_fb_back.sv -----
// back end: walks one command's byte sequence into the output register
module ssd_fb_back #(
    parameter int DIGITS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [7:0]           i_cfg_wr_data,
    input  logic                 i_q_vld,
    input  ssd_fb_pkg::t_cmd     i_q_cmd,
    input  logic [DIGITS*4-1:0]  i_q_dig,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [7:0]           o_data_byte,
    output logic                 o_frame_start,
    output logic                 o_frame_end,
    output logic                 o_last
);

    localparam int DW = DIGITS * 4;
    localparam int SW = $clog2(DIGITS + 3);

    logic [7:0]        r_bright_cmd;
    logic              r_cur_vld, n_cur_vld;
    ssd_fb_pkg::t_cmd  r_cmd, n_cmd;
    logic [DW-1:0]     r_dig, n_dig;
    logic [SW-1:0]     r_step, n_step;
    logic              r_out_vld, n_out_vld;
    logic [7:0]        r_data, n_data;
    logic              r_fs, n_fs, r_fe, n_fe, r_last, n_last;

    logic              adv;
    logic              is_digit;
    logic [SW-1:0]     last_step;
    logic              at_last;
    logic [3:0]        top_code;

    assign is_digit  = (r_cmd.kind == ssd_fb_pkg::K_DIGIT);
    assign last_step = is_digit ? SW'(3) : SW'(DIGITS + 2);
    assign at_last   = (r_step == last_step);
    assign adv       = !r_out_vld || !i_out_stall;
    assign o_pop     = i_q_vld && (!r_cur_vld || (adv && at_last));
    assign top_code  = r_dig[(DIGITS-1)*4 +: 4];

    assign o_out_valid   = r_out_vld;
    assign o_data_byte   = r_data;
    assign o_frame_start = r_fs;
    assign o_frame_end   = r_fe;
    assign o_last        = r_last;

    always_comb begin
        n_cur_vld = r_cur_vld;
        n_cmd     = r_cmd;
        n_dig     = r_dig;
        n_step    = r_step;
        n_out_vld = r_out_vld;
        n_data    = r_data;
        n_fs      = r_fs;
        n_fe      = r_fe;
        n_last    = r_last;
        if (adv) begin
            n_out_vld = r_cur_vld;
            if (r_cur_vld) begin
                n_step = r_step + SW'(1);
                n_last = 1'b0;
                if (r_step == SW'(0)) begin
                    n_data = ssd_fb_pkg::BYTE_DATA_WRITE;
                    n_fs   = 1'b1;
                    n_fe   = 1'b1;
                end else if (r_step == SW'(1)) begin
                    n_data = is_digit ? (ssd_fb_pkg::BYTE_ADDR_BASE | {6'd0, r_cmd.pos})
                                      : ssd_fb_pkg::BYTE_ADDR_BASE;
                    n_fs   = 1'b1;
                    n_fe   = 1'b0;
                end else if (at_last) begin
                    n_data    = r_bright_cmd;
                    n_fs      = 1'b1;
                    n_fe      = 1'b1;
                    n_last    = 1'b1;
                    n_cur_vld = 1'b0;
                end else begin
                    // segment bytes, most significant digit sits at the top
                    n_data = (r_cmd.kind == ssd_fb_pkg::K_CLEAR) ? ssd_fb_pkg::SEG_BLANK
                                                                 : ssd_fb_pkg::seg_of(top_code);
                    n_fs   = 1'b0;
                    n_fe   = is_digit || (r_step == SW'(DIGITS + 1));
                    for (int k = DIGITS - 1; k > 0; k--) begin
                        n_dig[k*4 +: 4] = r_dig[(k-1)*4 +: 4];
                    end
                    n_dig[3:0] = 4'd0;
                end
            end
        end
        if (o_pop) begin
            n_cur_vld = 1'b1;
            n_cmd     = i_q_cmd;
            n_dig     = i_q_dig;
            n_step    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright_cmd <= ssd_fb_pkg::BRIGHT_RESET;
            r_cur_vld    <= 1'b0;
            r_out_vld    <= 1'b0;
            r_step       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_bright_cmd <= i_cfg_wr_data;
            end
            r_cur_vld <= n_cur_vld;
            r_out_vld <= n_out_vld;
            r_step    <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_dig  <= n_dig;
        r_data <= n_data;
        r_fs   <= n_fs;
        r_fe   <= n_fe;
        r_last <= n_last;
    end

endmodule

// ----- rtl/seven_segment_display_frame_builder.sv -----
// top level of the seven-segment display frame builder
//
//   channel  direction  handshake                 payload
//   input    in         i_in_valid / o_in_stall   i_command i_number i_position i_digit_code
//   output   out        o_out_valid / i_out_stall o_data_byte o_frame_start o_frame_end o_last
//   config   in         i_cfg_wr_en               i_cfg_wr_data (brightness command)
//
// show number and clear emit DIGITS+3 bytes, show digit emits 4, one byte per cycle
// unless the output stalls; a queued next command's bytes follow with no gap
// show number runs one divide-by-ten per cycle in the front end, one per digit,
// overlapped with the previous command's bytes through a two-entry queue
// reset clears the queue and pipeline valids and loads brightness 0x8F
// a stalled output holds its byte; the front end keeps working until the queue fills
module seven_segment_display_frame_builder #(
    parameter int DIGITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_number,
    input  logic [1:0]  i_position,
    input  logic [3:0]  i_digit_code,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_data_byte,
    output logic        o_frame_start,
    output logic        o_frame_end,
    output logic        o_last
);

    localparam int DW = DIGITS * 4;
    localparam int QW = $bits(ssd_fb_pkg::t_cmd) + DW;

    logic              push, full, pop, q_vld;
    ssd_fb_pkg::t_cmd  f_cmd, q_cmd;
    logic [DW-1:0]     f_dig, q_dig;
    logic [QW-1:0]     q_out;

    ssd_fb_front #(.DIGITS(DIGITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_number     (i_number),
        .i_position   (i_position),
        .i_digit_code (i_digit_code),
        .o_push       (push),
        .o_cmd        (f_cmd),
        .o_dig        (f_dig),
        .i_full       (full)
    );

    ssd_fb_queue #(.WIDTH(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_cmd, f_dig}),
        .o_full  (full),
        .i_pop   (pop),
        .o_vld   (q_vld),
        .o_data  (q_out)
    );

    assign q_cmd = ssd_fb_pkg::t_cmd'(q_out[QW-1:DW]);
    assign q_dig = q_out[DW-1:0];

    ssd_fb_back #(.DIGITS(DIGITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_vld       (q_vld),
        .i_q_cmd       (q_cmd),
        .i_q_dig       (q_dig),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_data_byte   (o_data_byte),
        .o_frame_start (o_frame_start),
        .o_frame_end   (o_frame_end),
        .o_last        (o_last)
    );

endmodule

// ----- sim/seven_segment_display_frame_builder_checker.sv -----
`timescale 1ns / 100ps
// checker: watches both channels, predicts the display byte stream and compares it
module seven_segment_display_frame_builder_checker #(
    parameter int DIGITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_number,
    input  logic [1:0]  i_position,
    input  logic [3:0]  i_digit_code,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_start,
    input  logic        i_frame_end,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_item_count,
    output int          o_byte_count
);

    // segment patterns for 9 down to 0, one byte each
    localparam logic [79:0] GLYPHS = 80'h6F_7F_07_7D_6D_66_4F_5B_06_3F;

    typedef struct packed {
        logic [7:0] value;
        logic       starts;
        logic       stops;
        logic       is_last;
    } t_disp_byte;

    t_disp_byte expected_bytes[$];
    t_disp_byte want;
    logic [7:0] brightness = ssd_fb_pkg::BRIGHT_RESET;
    int         fails = 0;
    int         items = 0;
    int         bytes = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_item_count = 0;
        o_byte_count = 0;
    end

    function automatic logic [7:0] glyph(input logic [3:0] code);
        if (code > 4'd9) begin
            return ssd_fb_pkg::SEG_BLANK;
        end
        return GLYPHS[int'(code) * 8 +: 8];
    endfunction

    function automatic void add_byte(input logic [7:0] value, input logic starts,
                                     input logic stops, input logic is_last);
        t_disp_byte b;
        b.value   = value;
        b.starts  = starts;
        b.stops   = stops;
        b.is_last = is_last;
        expected_bytes.push_back(b);
    endfunction

    // one command: data-write frame, address frame with segments, brightness frame
    function automatic void predict_frames(input logic [1:0] cmd, input logic [15:0] num,
                                           input logic [1:0] pos, input logic [3:0] code);
        ssd_fb_pkg::t_kind kind;
        int                scale;
        if (cmd > ssd_fb_pkg::CMD_CLEAR) begin
            return;
        end
        kind = ssd_fb_pkg::t_kind'(cmd);
        add_byte(ssd_fb_pkg::BYTE_DATA_WRITE, 1'b1, 1'b1, 1'b0);
        if (kind == ssd_fb_pkg::K_DIGIT) begin
            add_byte(ssd_fb_pkg::BYTE_ADDR_BASE + 8'(pos), 1'b1, 1'b0, 1'b0);
            add_byte(glyph(code), 1'b0, 1'b1, 1'b0);
        end else begin
            add_byte(ssd_fb_pkg::BYTE_ADDR_BASE, 1'b1, 1'b0, 1'b0);
            scale = 1;
            for (int k = 1; k < DIGITS; k++) begin
                scale = scale * 10;
            end
            for (int i = DIGITS - 1; i >= 0; i--) begin
                if (kind == ssd_fb_pkg::K_NUMBER) begin
                    add_byte(glyph(4'((int'(num) / scale) % 10)), 1'b0, i == 0, 1'b0);
                end else begin
                    add_byte(ssd_fb_pkg::SEG_BLANK, 1'b0, i == 0, 1'b0);
                end
                scale = scale / 10;
            end
        end
        add_byte(brightness, 1'b1, 1'b1, 1'b1);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            brightness = ssd_fb_pkg::BRIGHT_RESET;
            expected_bytes.delete();
        end else begin
            if (i_cfg_wr_en) begin
                brightness = i_cfg_wr_data;
            end
            if (i_in_valid && !i_in_stall) begin
                predict_frames(i_command, i_number, i_position, i_digit_code);
                items++;
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("unexpected byte %h start %b stop %b last %b",
                                 i_data_byte, i_frame_start, i_frame_end, i_last);
                    end
                end else begin
                    want = expected_bytes.pop_front();
                    if (want.value !== i_data_byte || want.starts !== i_frame_start ||
                        want.stops !== i_frame_end || want.is_last !== i_last) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("byte %0d: expected %h/%b/%b/%b got %h/%b/%b/%b",
                                     bytes, want.value, want.starts, want.stops,
                                     want.is_last, i_data_byte, i_frame_start,
                                     i_frame_end, i_last);
                        end
                    end
                    bytes++;
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_bytes.size();
        o_item_count <= items;
        o_byte_count <= bytes;
    end

endmodule

// ----- sim/seven_segment_display_frame_builder_tb.sv -----
`timescale 1ns / 100ps
// testbench top: display commands, random output stalls, brightness changes and verdict
module seven_segment_display_frame_builder_tb;

    localparam int         DIGITS          = 4;
    localparam logic [1:0] CMD_UNUSED      = 2'd3;
    localparam int         DRAIN_CYCLES    = 3 * DIGITS + 12;
    localparam int         CYCLE_LIMIT     = 400000;
    localparam int         ITEMS_PER_PHASE = 66;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = 8'h00;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [1:0]  command     = ssd_fb_pkg::CMD_SHOW_NUMBER;
    logic [15:0] number      = 16'h0000;
    logic [1:0]  position    = 2'd0;
    logic [3:0]  digit_code  = 4'd0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [7:0]  data_byte;
    logic        frame_start;
    logic        frame_end;
    logic        last_byte;

    int fail_count;
    int pending;
    int item_count;
    int byte_count;
    int cycles     = 0;
    int stall_left = 0;
    int stall_odds = 0;
    int gap_odds   = 0;
    int settings   = 1;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    seven_segment_display_frame_builder #(
        .DIGITS(DIGITS)
    ) DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_command     (command),
        .i_number      (number),
        .i_position    (position),
        .i_digit_code  (digit_code),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_data_byte   (data_byte),
        .o_frame_start (frame_start),
        .o_frame_end   (frame_end),
        .o_last        (last_byte)
    );

    seven_segment_display_frame_builder_checker #(
        .DIGITS(DIGITS)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_command     (command),
        .i_number      (number),
        .i_position    (position),
        .i_digit_code  (digit_code),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_data_byte   (data_byte),
        .i_frame_start (frame_start),
        .i_frame_end   (frame_end),
        .i_last        (last_byte),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_item_count  (item_count),
        .o_byte_count  (byte_count)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still due", cycles, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver stalls in bursts of random length
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            stall_left <= $urandom_range(0, 17);
            out_stall  <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [15:0] num,
                             input logic [1:0] pos, input logic [3:0] code);
        in_valid   <= 1'b1;
        command    <= cmd;
        number     <= num;
        position   <= pos;
        digit_code <= code;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic pause_input(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // hold off until every predicted byte has come out, then let the block settle
    task automatic drain_all;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_brightness(input logic [7:0] value);
        drain_all();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        settings++;
    endtask

    task automatic random_item(output bit counted);
        logic [1:0]  cmd;
        logic [15:0] num;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            cmd = ssd_fb_pkg::CMD_SHOW_NUMBER;
        end else if (pick < 80) begin
            cmd = ssd_fb_pkg::CMD_SHOW_DIGIT;
        end else if (pick < 92) begin
            cmd = ssd_fb_pkg::CMD_CLEAR;
        end else begin
            cmd = CMD_UNUSED;
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            num = 16'h0000;
        end else if (pick == 1) begin
            num = 16'hFFFF;
        end else if (pick == 2) begin
            num = 16'd9999;
        end else begin
            num = 16'($urandom);
        end
        send_item(cmd, num, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
        counted = (cmd != CMD_UNUSED);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            pause_input($urandom_range(1, 18));
        end
    endtask

    initial begin
        bit   counted;
        int   sent;
        logic [7:0] levels [5];
        int   stall_plan [5];
        int   gap_plan [5];

        levels     = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom), 8'h8F};
        stall_plan = '{3, 8, 0, 5, 0};
        gap_plan   = '{4, 0, 3, 5, 0};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: number extremes, every glyph, blanks, clear, unused command
        stall_odds <= 4;
        send_item(ssd_fb_pkg::CMD_SHOW_NUMBER, 16'd0, 2'd3, 4'd15);
        send_item(ssd_fb_pkg::CMD_SHOW_NUMBER, 16'd1234, 2'd0, 4'd0);
        send_item(ssd_fb_pkg::CMD_SHOW_NUMBER, 16'd5678, 2'd2, 4'd9);
        send_item(ssd_fb_pkg::CMD_SHOW_NUMBER, 16'd9999, 2'd1, 4'd10);
        send_item(ssd_fb_pkg::CMD_SHOW_NUMBER, 16'd10000, 2'd0, 4'd5);
        send_item(ssd_fb_pkg::CMD_SHOW_NUMBER, 16'hFFFF, 2'd3, 4'd15);
        for (int c = 0; c < 12; c++) begin
            send_item(ssd_fb_pkg::CMD_SHOW_DIGIT, 16'($urandom), 2'(c % 4), 4'(c));
        end
        send_item(ssd_fb_pkg::CMD_SHOW_DIGIT, 16'hFFFF, 2'd3, 4'd15);
        send_item(ssd_fb_pkg::CMD_CLEAR, 16'hFFFF, 2'd3, 4'd15);
        send_item(CMD_UNUSED, 16'h0000, 2'd0, 4'd0);
        send_item(CMD_UNUSED, 16'hFFFF, 2'd3, 4'd15);
        send_item(ssd_fb_pkg::CMD_CLEAR, 16'h0000, 2'd0, 4'd0);

        // random phases, each under its own brightness and idling mix; the last is calm
        for (int phase = 0; phase < 5; phase++) begin
            write_brightness(levels[phase]);
            stall_odds <= stall_plan[phase];
            gap_odds   = gap_plan[phase];
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                random_item(counted);
                if (counted) begin
                    sent++;
                end
            end
        end

        drain_all();
        $display("%0d commands sent, %0d display bytes checked", item_count, byte_count);
        $display("covered %0d brightness settings, stalls on both sides and a calm tail",
                 settings);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
